// File: rtl/core/blht_pkg.sv
package blht_pkg;

  localparam int CMD_W   = 2;
  localparam int CTR_W   = 14;
  localparam int EXT_W   = 13;
  localparam int CLS_W   = 8;
  localparam int QRY_W   = 18;
  localparam int ENTRY_W = CLS_W + 2 * EXT_W + 2 * CTR_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FULL,
    RES_HIT
  } res_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [CLS_W-1:0]        cls;
    logic [EXT_W-1:0]        h;
    logic [EXT_W-1:0]        w;
    logic signed [CTR_W-1:0] cy;
    logic signed [CTR_W-1:0] cx;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic load_query;
    logic scan;
    logic load_out;
    res_e out_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/blht_if.sv
interface blht_req_if;
  import blht_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [CTR_W-1:0]  center_x;
  logic signed [CTR_W-1:0]  center_y;
  logic [EXT_W-1:0]         box_width;
  logic [EXT_W-1:0]         box_height;
  logic [CLS_W-1:0]         class_code;
  logic signed [QRY_W-1:0]  query_x;
  logic signed [QRY_W-1:0]  query_y;

  modport source (
    output valid, command, center_x, center_y, box_width, box_height, class_code,
           query_x, query_y,
    input  ready
  );

  modport sink (
    input  valid, command, center_x, center_y, box_width, box_height, class_code,
           query_x, query_y,
    output ready
  );
endinterface

interface blht_rsp_if;
  import blht_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic             found;
  logic [CLS_W-1:0] label;

  modport source (
    output valid, status, found, label,
    input  ready
  );

  modport sink (
    input  valid, status, found, label,
    output ready
  );
endinterface

// File: rtl/core/box_label_hit_test_unit.sv
// box label hit test unit
// req_i carries one command per transaction: clear the box table, add a
// box (center, width, height, class code) or query a point given with
// FRACTION_BITS fraction bits. rsp_o returns exactly one result per
// request: status (add dropped on a full table), found and label.
// boxes live in a single-port-read RAM of MAX_BOXES entries; a query
// reads one entry per cycle in insertion order and stops at the first
// box whose open interior holds the point.
// latency: clear and add give their result one cycle after acceptance;
// a query checks each entry from the registered read data of the table
// RAM and loads the result register on the first hit, or on a miss
// once every stored box is checked (at once on an empty table).
// one request is processed at a time; req_i.ready is high only while
// idle with the result register empty or being drained.
// a stalled receiver holds the result in the output register and blocks
// further requests until it is taken.
// reset empties the table and drops any pending result; the RAM itself
// is not cleared, entries past the box count are never read.
module box_label_hit_test_unit #(
  parameter int MAX_BOXES     = 16,
  parameter int FRACTION_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blht_req_if.sink    req_i,
  blht_rsp_if.source  rsp_o
);
  import blht_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  blht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .command_i   (req_i.command),
    .req_ready_o (req_i.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  blht_dp #(
    .MAX_BOXES     (MAX_BOXES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .stat_o       (dp_stat),
    .center_x_i   (req_i.center_x),
    .center_y_i   (req_i.center_y),
    .box_width_i  (req_i.box_width),
    .box_height_i (req_i.box_height),
    .class_code_i (req_i.class_code),
    .query_x_i    (req_i.query_x),
    .query_y_i    (req_i.query_y),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .found_o      (rsp_o.found),
    .label_o      (rsp_o.label)
  );

endmodule

// File: rtl/core/blht_ram.sv
module blht_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/blht_ctrl.sv
module blht_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [blht_pkg::CMD_W-1:0] command_i,
  output logic                       req_ready_o,
  input  blht_pkg::dp_stat_t         stat_i,
  output blht_pkg::ctl_cmd_t         cmd_o
);
  import blht_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_e'(command_i) == CMD_QUERY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.hit || stat_i.scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_sel = RES_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CMD_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.load_out = 1'b1;
            end
            CMD_ADD: begin
              cmd_o.load_out = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_sel = RES_FULL;
              end else begin
                cmd_o.add = 1'b1;
              end
            end
            CMD_QUERY: begin
              cmd_o.load_query = 1'b1;
            end
            default: begin
              cmd_o.load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = RES_HIT;
        end else if (stat_i.scan_done) begin
          cmd_o.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("result loaded while output register busy");

  a_query_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_e'(command_i) == CMD_QUERY)) |=> (state_q == ST_SCAN))
    else $error("query transaction did not start a scan");

  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && stat_i.hit) |=> (state_q == ST_IDLE))
    else $error("scan continued after a hit");

endmodule

// File: rtl/core/blht_dp.sv
module blht_dp #(
  parameter int MAX_BOXES     = 16,
  parameter int FRACTION_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  blht_pkg::ctl_cmd_t                cmd_i,
  output blht_pkg::dp_stat_t                stat_o,
  input  logic signed [blht_pkg::CTR_W-1:0] center_x_i,
  input  logic signed [blht_pkg::CTR_W-1:0] center_y_i,
  input  logic [blht_pkg::EXT_W-1:0]        box_width_i,
  input  logic [blht_pkg::EXT_W-1:0]        box_height_i,
  input  logic [blht_pkg::CLS_W-1:0]        class_code_i,
  input  logic signed [blht_pkg::QRY_W-1:0] query_x_i,
  input  logic signed [blht_pkg::QRY_W-1:0] query_y_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              status_o,
  output logic                              found_o,
  output logic [blht_pkg::CLS_W-1:0]        label_o
);
  import blht_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int AW    = $clog2(MAX_BOXES);
  localparam int DW    = CTR_W + 1;
  localparam int SW    = DW + FRACTION_BITS;
  localparam int CW    = ((SW > QRY_W) ? SW : QRY_W) + 1;

  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic signed [QRY_W-1:0] qx_q, qy_q;
  logic                    out_valid_q, out_valid_d;
  logic                    status_q, found_q;
  logic [CLS_W-1:0]        label_q;

  logic                    rd_en;
  logic                    out_free;
  logic [ENTRY_W-1:0]      rdata;
  entry_t                  ent, wr_ent;
  logic                    in_x, in_y;

  function automatic logic inside_ext(logic signed [QRY_W-1:0] q,
                                      logic signed [CTR_W-1:0] c,
                                      logic [EXT_W-1:0] ext);
    logic signed [DW-1:0] half;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] qe;
    half = $signed({{(DW-EXT_W+1){1'b0}}, ext[EXT_W-1:1]});
    lo   = CW'(DW'(c) - half) <<< FRACTION_BITS;
    hi   = CW'(DW'(c) + half) <<< FRACTION_BITS;
    qe   = CW'(q);
    return (qe > lo) && (qe < hi);
  endfunction

  assign wr_ent.cls = class_code_i;
  assign wr_ent.h   = box_height_i;
  assign wr_ent.w   = box_width_i;
  assign wr_ent.cy  = center_y_i;
  assign wr_ent.cx  = center_x_i;

  assign rd_en = cmd_i.scan && (idx_q < count_q);

  blht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_ent),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign ent  = entry_t'(rdata);
  assign in_x = inside_ext(qx_q, ent.cx, ent.w);
  assign in_y = inside_ext(qy_q, ent.cy, ent.h);

  assign out_free         = !out_valid_q || out_ready_i;
  assign stat_o.full      = (count_q == CNT_W'(MAX_BOXES));
  assign stat_o.scan_done = !pend_q && (idx_q == count_q);
  assign stat_o.hit       = pend_q && in_x && in_y;
  assign stat_o.out_free  = out_free;

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.add) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    idx_d  = idx_q;
    pend_d = rd_en;
    if (cmd_i.load_query) begin
      idx_d = '0;
    end else if (rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
    end
    if (cmd_i.load_out) begin
      status_q <= (cmd_i.out_sel == RES_FULL);
      found_q  <= (cmd_i.out_sel == RES_HIT);
      label_q  <= (cmd_i.out_sel == RES_HIT) ? ent.cls : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign label_o     = label_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BOXES))
    else $error("box count beyond table depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (idx_q <= count_q))
    else $error("scan index past box count");

  a_add_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |-> (count_q < CNT_W'(MAX_BOXES)))
    else $error("write into a full table");

endmodule
